@@ rtl/tocm_pkg.sv @@
// Package for the timestamp ordered channel merge.
// Holds the beat structs, request codes and default sizes; no dependencies.
package tocm_pkg;

  localparam int unsigned ChannelsDef   = 16;
  localparam int unsigned QueueDepthDef = 64;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  chan;
    logic [31:0] time_tag;
    logic [15:0] energy;
  } in_beat_t;

  typedef struct packed {
    logic        valid_res;
    logic [3:0]  out_chan;
    logic [63:0] ext_time;
    logic [15:0] out_energy;
    logic        more_left;
    logic        overflow;
  } out_beat_t;

endpackage

@@ rtl/timestamp_ordered_channel_merge.sv @@
// Top level of the timestamp ordered channel merge.
// Depends on tocm_pkg for beat structs, request codes and default sizes.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------
//  in      | in_valid_i / in_ready_o   | in_data_i  (in_beat_t)
//  out     | out_valid_o / out_ready_i | out_data_o (out_beat_t)
//
// A read that pops a channel with more events queued is followed by a refill
// state, with in_ready_o low, that loads the next head from the event memory's
// registered read port into the head register file.
// Reset (rst_ni, async, low) holds in_ready_o low, empties all queues, zeroes
// wrap counts and last tags, and clears overflow; memory is not cleared.
// A read result held in the output register stalls further input until taken.
module timestamp_ordered_channel_merge #(
  parameter int unsigned CHANNELS    = tocm_pkg::ChannelsDef,
  parameter int unsigned QUEUE_DEPTH = tocm_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tocm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tocm_pkg::out_beat_t out_data_o
);
  import tocm_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NP = 2 ** CW;
  localparam int unsigned MD = CHANNELS * (2 ** AW);

  typedef struct packed {
    logic          vld;
    logic [31:0]   tag;
    logic [CW-1:0] idx;
  } node_t;

  // queue bookkeeping
  logic [PW-1:0] fill_q [CHANNELS];
  logic [PW-1:0] rd_q   [CHANNELS];
  logic [31:0]   last_q [CHANNELS];
  logic [31:0]   wrap_q [CHANNELS];
  logic [47:0]   head_q [CHANNELS];   // {energy, tag} of each queue head
  logic          ovf_q;

  logic [47:0]   mem_q [MD];
  logic [47:0]   rdata_q;
  logic          refill_q;
  logic [CW-1:0] refill_ch_q;

  logic          out_valid_q;
  out_beat_t     out_q;

  logic          accept;
  logic [CW-1:0] in_ch;
  logic          ch_ok;
  logic [CHANNELS-1:0] pending;
  node_t         tree [2*NP];
  node_t         best;
  logic [PW-1:0] best_rd_nx;
  logic          best_more;
  logic [31:0]   best_wrap_nx;
  logic [47:0]   best_head;
  logic          more_any;

  assign in_ready_o = rst_ni && !refill_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_ch      = CW'(in_data_i.chan);
  assign ch_ok      = ({28'd0, in_data_i.chan} < 32'(CHANNELS));

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pending[c] = rd_q[c] < fill_q[c];
    end
  end

  // Pick the smallest head tag with a registered-free compare tree; left wins ties.
  always_comb begin
    for (int n = 0; n < NP; n++) begin
      if (n < CHANNELS) begin
        tree[NP+n].vld = pending[n];
        tree[NP+n].tag = head_q[n][31:0];
      end else begin
        tree[NP+n].vld = 1'b0;
        tree[NP+n].tag = '0;
      end
      tree[NP+n].idx = CW'(n);
    end
    tree[0] = '0;
    for (int n = NP - 1; n >= 1; n--) begin
      if (tree[2*n+1].vld && (!tree[2*n].vld || tree[2*n+1].tag < tree[2*n].tag)) begin
        tree[n] = tree[2*n+1];
      end else begin
        tree[n] = tree[2*n];
      end
    end
    best = tree[1];
  end

  always_comb begin
    best_rd_nx   = rd_q[best.idx] + PW'(1);
    best_more    = best_rd_nx < fill_q[best.idx];
    best_head    = head_q[best.idx];
    best_wrap_nx = wrap_q[best.idx];
    if (best_head[31:0] < last_q[best.idx]) begin
      best_wrap_nx = wrap_q[best.idx] + 32'd1;
    end
    more_any = best_more;
    for (int c = 0; c < CHANNELS; c++) begin
      if (pending[c] && CW'(c) != best.idx) begin
        more_any = 1'b1;
      end
    end
  end

  // Event memory: one write port for appends, one registered read for refills.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.req_type == REQ_APPEND && ch_ok &&
        fill_q[in_ch] < PW'(QUEUE_DEPTH)) begin
      mem_q[{in_ch, fill_q[in_ch][AW-1:0]}] <= {in_data_i.energy, in_data_i.time_tag};
    end
    rdata_q <= mem_q[{best.idx, best_rd_nx[AW-1:0]}];
  end

  // Head register file: loaded on append to an empty queue or on refill.
  always_ff @(posedge clk_i) begin
    if (refill_q) begin
      head_q[refill_ch_q] <= rdata_q;
    end else if (accept && in_data_i.req_type == REQ_APPEND && ch_ok &&
                 fill_q[in_ch] == rd_q[in_ch]) begin
      head_q[in_ch] <= {in_data_i.energy, in_data_i.time_tag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fill_q[c] <= '0;
        rd_q[c]   <= '0;
        last_q[c] <= '0;
        wrap_q[c] <= '0;
      end
      ovf_q       <= 1'b0;
      refill_q    <= 1'b0;
      refill_ch_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      refill_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        case (in_data_i.req_type)
          REQ_CLEAR: begin
            for (int c = 0; c < CHANNELS; c++) begin
              fill_q[c] <= '0;
              rd_q[c]   <= '0;
            end
            ovf_q <= 1'b0;
          end
          REQ_APPEND: begin
            if (ch_ok) begin
              if (fill_q[in_ch] < PW'(QUEUE_DEPTH)) begin
                fill_q[in_ch] <= fill_q[in_ch] + PW'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end
          end
          REQ_READ: begin
            out_valid_q <= 1'b1;
            if (best.vld) begin
              // pop the winner, extend its tag, schedule a head refill
              rd_q[best.idx]   <= best_rd_nx;
              wrap_q[best.idx] <= best_wrap_nx;
              last_q[best.idx] <= best_head[31:0];
              refill_q         <= best_more;
              refill_ch_q      <= best.idx;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.req_type == REQ_READ) begin
      out_q.overflow <= ovf_q;
      if (best.vld) begin
        out_q.valid_res  <= 1'b1;
        out_q.out_chan   <= 4'(best.idx);
        out_q.ext_time   <= {best_wrap_nx, best_head[31:0]};
        out_q.out_energy <= best_head[47:32];
        out_q.more_left  <= more_any;
      end else begin
        out_q.valid_res  <= 1'b0;
        out_q.out_chan   <= '0;
        out_q.ext_time   <= '0;
        out_q.out_energy <= '0;
        out_q.more_left  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/tb_timestamp_ordered_channel_merge.sv @@
// Testbench for timestamp ordered channel merge: directed rows, overflow fill, random traffic.
// Depends on tocm_pkg and timestamp_ordered_channel_merge; checks every read beat in order.
module tb_timestamp_ordered_channel_merge;
  import tocm_pkg::*;

  localparam int unsigned NumChan  = ChannelsDef;
  localparam int unsigned Depth    = QueueDepthDef;
  localparam int unsigned NumItems = 850;

  // Unused request code, ignored by the block.
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  timestamp_ordered_channel_merge i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the queues, wrap counters and overflow flag.
  logic [47:0] queue_mem [NumChan][Depth];
  int unsigned fill_cnt  [NumChan];
  int unsigned rd_idx    [NumChan];
  logic [31:0] prev_tag  [NumChan];
  logic [31:0] wraps     [NumChan];
  logic        ovf_sticky;

  out_beat_t   pending_reads [$];
  int          err_cnt;
  bit          no_idle;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one accepted beat to the shadow state; push the read result it causes.
  task automatic merge_model(input in_beat_t b);
    out_beat_t   r;
    bit          found;
    int unsigned best;
    logic [31:0] best_tag;
    logic [47:0] ent;
    begin
      r = '0;
      case (b.req_type)
        REQ_CLEAR: begin
          for (int c = 0; c < NumChan; c++) begin
            fill_cnt[c] = 0;
            rd_idx[c] = 0;
          end
          ovf_sticky = 1'b0;
        end
        REQ_APPEND: begin
          if (b.chan < NumChan) begin
            if (fill_cnt[b.chan] >= Depth) begin
              ovf_sticky = 1'b1;
            end else begin
              queue_mem[b.chan][fill_cnt[b.chan]] = {b.energy, b.time_tag};
              fill_cnt[b.chan]++;
            end
          end
        end
        REQ_READ: begin
          found = 1'b0;
          best = 0;
          best_tag = '0;
          // Pick the smallest head tag; the strict compare keeps the lowest channel on ties.
          for (int c = 0; c < NumChan; c++) begin
            if (rd_idx[c] < fill_cnt[c] && (!found || queue_mem[c][rd_idx[c]][31:0] < best_tag)) begin
              found = 1'b1;
              best = c;
              best_tag = queue_mem[c][rd_idx[c]][31:0];
            end
          end
          if (found) begin
            ent = queue_mem[best][rd_idx[best]];
            rd_idx[best]++;
            if (ent[31:0] < prev_tag[best]) wraps[best] = wraps[best] + 32'd1;
            prev_tag[best] = ent[31:0];
            r.valid_res = 1'b1;
            r.out_chan = best[3:0];
            r.ext_time = {wraps[best], ent[31:0]};
            r.out_energy = ent[47:32];
            for (int c = 0; c < NumChan; c++) begin
              if (rd_idx[c] < fill_cnt[c]) r.more_left = 1'b1;
            end
          end
          r.overflow = ovf_sticky;
          pending_reads.push_back(r);
        end
        default: ;
      endcase
    end
  endtask

  // Drive one beat and hold it until accepted; idle at random beforehand.
  task automatic send_beat(input in_beat_t b);
    begin
      while (!no_idle && $urandom_range(99) < 13) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i <= b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      merge_model(b);
    end
  endtask

  function automatic in_beat_t mk(input logic [1:0] req, input logic [3:0] ch,
                                  input logic [31:0] tag, input logic [15:0] en);
    in_beat_t b;
    begin
      b.req_type = req;
      b.chan = ch;
      b.time_tag = tag;
      b.energy = en;
      return b;
    end
  endfunction

  // Receiver: random stall, compare each read beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected read beat %h", $time, out_data_o);
          err_cnt++;
        end else begin
          out_beat_t e;
          e = pending_reads.pop_front();
          if (e.valid_res !== out_data_o.valid_res || e.out_chan !== out_data_o.out_chan ||
              e.ext_time !== out_data_o.ext_time || e.out_energy !== out_data_o.out_energy ||
              e.more_left !== out_data_o.more_left || e.overflow !== out_data_o.overflow) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, out_data_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // Directed rows; a known result is given where it is obvious, else the shadow state decides.
  typedef struct {
    in_beat_t  beat;
    bit        known;
    out_beat_t res;
  } row_t;

  row_t dir_rows [$];

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_beat_t b;
    int       k;
    int       wait_cyc;
    err_cnt = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    ovf_sticky = 1'b0;
    for (int c = 0; c < NumChan; c++) begin
      fill_cnt[c] = 0;
      rd_idx[c] = 0;
      prev_tag[c] = '0;
      wraps[c] = '0;
    end

    // Directed: empty read, extremes, ties, wrap, unused code, clear.
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b1, '0});
    dir_rows.push_back('{mk(REQ_NONE, 4'hF, '1, '1), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_APPEND, 4'hF, '1, '1), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_APPEND, 4'h0, '1, 16'h0), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_APPEND, 4'h3, 32'd0, 16'h8001), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b1,
                         '{1'b1, 4'h3, 64'd0, 16'h8001, 1'b1, 1'b0}});
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_APPEND, 4'h0, 32'h5, 16'h1), 1'b0, '0});
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b1,
                         '{1'b1, 4'h0, {32'd1, 32'h5}, 16'h1, 1'b0, 1'b0}});
    dir_rows.push_back('{mk(REQ_READ, 4'd0, 32'd0, 16'd0), 1'b1, '0});
    dir_rows.push_back('{mk(REQ_CLEAR, 4'd0, 32'd0, 16'd0), 1'b0, '0});

    // Hold reset low, then release it before the first beat.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat);
      if (dir_rows[i].known && pending_reads[$] !== dir_rows[i].res) begin
        $display("%0t: directed row %0d expected %h actual %h", $time, i,
                 dir_rows[i].res, pending_reads[$]);
        err_cnt++;
      end
    end
    // Fill channel 2 past its depth to hit overflow, then read it, clear, and read again.
    for (int i = 0; i <= Depth; i++) begin
      send_beat(mk(REQ_APPEND, 4'd2, $urandom, 16'($urandom)));
    end
    send_beat(mk(REQ_READ, 4'd0, 32'd0, 16'd0));
    send_beat(mk(REQ_CLEAR, 4'd0, 32'd0, 16'd0));
    send_beat(mk(REQ_READ, 4'd0, 32'd0, 16'd0));

    // Random: mostly appends and reads, some clears, few unused codes.
    for (int n = 0; n < NumItems; n++) begin
      no_idle = (n >= 300 && n < 420);
      if (n == 500) begin
        // Hold off until every expected read beat is back.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_reads.size() != 0) @(posedge clk_i);
      end
      k = $urandom_range(99);
      b.chan = 4'($urandom);
      b.time_tag = ($urandom_range(3) == 0) ? $urandom : {28'h0, 4'($urandom)};
      if ($urandom_range(7) == 0) b.time_tag = '1;
      b.energy = 16'($urandom);
      if (k < 3) b.req_type = REQ_CLEAR;
      else if (k < 5) b.req_type = REQ_NONE;
      else if (k < 55) b.req_type = REQ_APPEND;
      else b.req_type = REQ_READ;
      send_beat(b);
    end
    in_valid_i <= 1'b0;

    wait_cyc = 0;
    while (pending_reads.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_reads.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
